### hw/rtl/i2cq_pkg.sv
// i2cq_pkg: shared constants, codes, header/result types and helpers for the
// I2C transaction queue master. No dependencies.
package i2cq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_BYTES   = 16;

  // field widths fixed by the interface
  localparam int KIND_W = 3;
  localparam int ACT_W  = 3;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 5;
  localparam int POS_W  = 4;

  localparam int SLOT_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int FILL_W   = $clog2(MAX_BYTES + 1);
  localparam int BUF_AW   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int WS_DEPTH = QUEUE_DEPTH * MAX_BYTES;
  localparam int WS_AW    = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;

  // input kinds
  localparam logic [KIND_W-1:0] KIND_ENQ    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WDONE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RDONE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BUSERR = 3'd4;

  // result actions
  localparam logic [ACT_W-1:0] ACT_ADDR    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DATA    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DELIVER = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DROP    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ERROR   = 3'd4;

  // direction bit of the address byte
  localparam logic [BYTE_W-1:0] DIR_WRITE = 8'h00;
  localparam logic [BYTE_W-1:0] DIR_READ  = 8'h01;

  typedef struct packed {
    logic              dlv;
    logic [LEN_W-1:0]  rlen;
    logic [LEN_W-1:0]  wlen;
    logic [BYTE_W-1:0] addr;
  } hdr_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] bus_byte;
    logic [POS_W-1:0]  byte_position;
    logic [LEN_W-1:0]  delivered_length;
    logic              last;
  } result_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (int'(v) > MAX_BYTES) r = LEN_W'(MAX_BYTES);
    return r;
  endfunction

  // sum of a slot and an offset below twice the depth, folded into the ring
  function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = s;
    if (s >= SUM_W'(QUEUE_DEPTH)) r = s - SUM_W'(QUEUE_DEPTH);
    return r[SLOT_W-1:0];
  endfunction

  function automatic result_t mk_result(input logic [ACT_W-1:0] act,
                                        input logic [BYTE_W-1:0] b,
                                        input logic [POS_W-1:0] pos,
                                        input logic [LEN_W-1:0] len,
                                        input logic lst);
    result_t r;
    r.action           = act;
    r.bus_byte         = b;
    r.byte_position    = pos;
    r.delivered_length = len;
    r.last             = lst;
    return r;
  endfunction

endpackage

### hw/rtl/i2cq_ram.sv
// i2cq_ram: generic simple dual-port RAM, one write port, one read port with
// registered read data. No dependencies.
module i2cq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/i2cq_out_reg.sv
// i2cq_out_reg: single-entry result register between the sequencer and the
// valid/stall result channel. Depends on i2cq_pkg.
module i2cq_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  i2cq_pkg::result_t push_res,
  input  logic              out_stall,
  output logic              out_valid,
  output i2cq_pkg::result_t out_res,
  output logic              free
);
  import i2cq_pkg::*;

  // slot can take a new result if empty or being drained this cycle
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res <= push_res;
    end
  end

endmodule

### hw/rtl/i2c_transaction_queue_master.sv
// i2c_transaction_queue_master: queue of I2C write-then-read transactions.
// Depends on i2cq_pkg, i2cq_ram, i2cq_out_reg.
// One item at a time: in_stall stays high until the sequencer returns to IDLE, and a
// header that starts the bus, a final read event with its delivered bytes and the start
// of the next transaction all finish first. Result stalls hold the sequencer too.
// Reset: queue empty, bus idle; the RAMs hold no reset and need no clearing.
module i2c_transaction_queue_master (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [i2cq_pkg::KIND_W-1:0]   kind,
  input  logic [i2cq_pkg::BYTE_W-1:0]   device_address,
  input  logic [i2cq_pkg::LEN_W-1:0]    write_count,
  input  logic [i2cq_pkg::LEN_W-1:0]    read_count,
  input  logic                          wants_delivery,
  input  logic [i2cq_pkg::BYTE_W-1:0]   data_byte,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [i2cq_pkg::ACT_W-1:0]    action,
  output logic [i2cq_pkg::BYTE_W-1:0]   bus_byte,
  output logic [i2cq_pkg::POS_W-1:0]    byte_position,
  output logic [i2cq_pkg::LEN_W-1:0]    delivered_length,
  output logic                          last
);
  import i2cq_pkg::*;

  // Sequencer states. One item at a time: IDLE takes it, EXEC decodes it,
  // and the rest fetch RAM data and hand results to the output register.
  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_EXEC       = 9'b000000010,
    S_WR_DATA    = 9'b000000100,
    S_PUSH_ONE   = 9'b000001000,
    S_DLV_RD     = 9'b000010000,
    S_DLV_PUSH   = 9'b000100000,
    S_POP        = 9'b001000000,
    S_START_WAIT = 9'b010000000,
    S_START      = 9'b100000000
  } state_t;

  // Bus phase of the head transaction.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_WRITING = 3'b010,
    PH_READING = 3'b100
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;

  logic [SLOT_W-1:0] head_slot, head_next;
  logic [CNT_W-1:0]  queued_count, count_next;
  logic [LEN_W-1:0]  byte_counter, bcnt_next;
  logic [FILL_W-1:0] load_fill, fill_next;
  logic [LEN_W-1:0]  dcount, dcount_next;
  result_t           res, res_next;

  // latched item
  logic [KIND_W-1:0] itm_kind;
  logic [BYTE_W-1:0] itm_addr;
  logic [LEN_W-1:0]  itm_wcnt;
  logic [LEN_W-1:0]  itm_rcnt;
  logic              itm_dlv;
  logic [BYTE_W-1:0] itm_data;

  // output register hookup
  logic    push;
  result_t push_res;
  result_t out_res;
  logic    out_free;

  // Shared slot adder: tail for a header, newest slot for a load, head+1 on
  // pop. Its operand is picked by the sequencer.
  logic [SUM_W-1:0]  slot_off;
  logic [SLOT_W-1:0] slot_sum;

  // RAM ports
  logic              hdr_we;
  hdr_t              hdr_wdata;
  logic [$bits(hdr_t)-1:0] hdr_rdata;
  hdr_t              hdr_q;
  logic              ws_we;
  logic [WS_AW-1:0]  ws_waddr, ws_raddr;
  logic [BYTE_W-1:0] ws_rdata;
  logic              rb_we;
  logic [BUF_AW-1:0] rb_waddr, rb_raddr;
  logic [BYTE_W-1:0] rb_rdata;

  logic [LEN_W+BUF_AW-1:0] bc_ext, dc_ext;
  logic [LEN_W-1:0]  bcnt_inc, dcount_inc;
  logic              q_full, load_ok, bc_in_buf, dlv_last;

  assign in_stall = (state != S_IDLE);

  assign q_full     = (queued_count >= CNT_W'(QUEUE_DEPTH));
  assign load_ok    = (queued_count != '0) && (load_fill < FILL_W'(MAX_BYTES));
  assign bc_in_buf  = (int'(byte_counter) < MAX_BYTES);
  assign bcnt_inc   = byte_counter + LEN_W'(1);
  assign dcount_inc = dcount + LEN_W'(1);
  // final delivered byte is the last result only when no next start follows
  assign dlv_last   = (dcount_inc == hdr_q.rlen) && (queued_count <= CNT_W'(1));

  always_comb begin
    slot_off = SUM_W'(queued_count);
    case (state)
      S_EXEC: begin
        if (itm_kind == KIND_LOAD) begin
          slot_off = SUM_W'(queued_count) - SUM_W'(1);
        end
      end
      S_POP: slot_off = SUM_W'(1);
      default: slot_off = SUM_W'(queued_count);
    endcase
  end

  assign slot_sum = slot_wrap(SUM_W'(head_slot) + slot_off);

  // header store: written at the tail, read at the head
  assign hdr_wdata.addr = itm_addr;
  assign hdr_wdata.wlen = sat_len(itm_wcnt);
  assign hdr_wdata.rlen = sat_len(itm_rcnt);
  assign hdr_wdata.dlv  = itm_dlv;
  assign hdr_q          = hdr_t'(hdr_rdata);

  i2cq_ram #(
    .WIDTH ($bits(hdr_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (slot_sum),
    .wdata (hdr_wdata),
    .raddr (head_slot),
    .rdata (hdr_rdata)
  );

  // write-byte store: one row of MAX_BYTES per slot
  assign ws_waddr = WS_AW'(slot_sum) * WS_AW'(MAX_BYTES) + WS_AW'(load_fill);
  assign ws_raddr = WS_AW'(head_slot) * WS_AW'(MAX_BYTES) + WS_AW'(byte_counter);

  i2cq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WS_DEPTH)
  ) u_ws_ram (
    .clk   (clk),
    .we    (ws_we),
    .waddr (ws_waddr),
    .wdata (itm_data),
    .raddr (ws_raddr),
    .rdata (ws_rdata)
  );

  // read buffer for the head transaction
  assign bc_ext   = {{BUF_AW{1'b0}}, byte_counter};
  assign dc_ext   = {{BUF_AW{1'b0}}, dcount};
  assign rb_waddr = bc_ext[BUF_AW-1:0];
  assign rb_raddr = dc_ext[BUF_AW-1:0];

  i2cq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_BYTES)
  ) u_rb_ram (
    .clk   (clk),
    .we    (rb_we),
    .waddr (rb_waddr),
    .wdata (itm_data),
    .raddr (rb_raddr),
    .rdata (rb_rdata)
  );

  always_comb begin
    state_next  = state;
    phase_next  = phase;
    head_next   = head_slot;
    count_next  = queued_count;
    bcnt_next   = byte_counter;
    fill_next   = load_fill;
    dcount_next = dcount;
    res_next    = res;
    push        = 1'b0;
    push_res    = res;
    hdr_we      = 1'b0;
    ws_we       = 1'b0;
    rb_we       = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next = S_IDLE;
        case (itm_kind)
          KIND_ENQ: begin
            if (q_full) begin
              // dropped; loads that follow are ignored
              fill_next  = FILL_W'(MAX_BYTES);
              res_next   = mk_result(ACT_DROP, '0, '0, '0, 1'b1);
              state_next = S_PUSH_ONE;
            end else begin
              hdr_we     = 1'b1;
              count_next = queued_count + CNT_W'(1);
              fill_next  = '0;
              if (phase == PH_IDLE) begin
                state_next = S_START_WAIT;
              end
            end
          end
          KIND_LOAD: begin
            if (load_ok) begin
              ws_we     = 1'b1;
              fill_next = load_fill + FILL_W'(1);
            end
          end
          KIND_WDONE: begin
            if (phase == PH_WRITING) begin
              if (byte_counter < hdr_q.wlen) begin
                state_next = S_WR_DATA;
              end else begin
                bcnt_next  = '0;
                phase_next = PH_READING;
                res_next   = mk_result(ACT_ADDR, hdr_q.addr | DIR_READ, '0, '0, 1'b1);
                state_next = S_PUSH_ONE;
              end
            end
          end
          KIND_RDONE: begin
            if (phase == PH_READING) begin
              rb_we = bc_in_buf;
              if (bcnt_inc >= hdr_q.rlen) begin
                phase_next  = PH_IDLE;
                bcnt_next   = '0;
                dcount_next = '0;
                if (hdr_q.dlv && (hdr_q.rlen != '0)) begin
                  state_next = S_DLV_RD;
                end else begin
                  state_next = S_POP;
                end
              end else begin
                bcnt_next = bcnt_inc;
              end
            end
          end
          KIND_BUSERR: begin
            res_next   = mk_result(ACT_ERROR, '0, '0, '0, 1'b1);
            state_next = S_PUSH_ONE;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      S_WR_DATA: begin
        // write-store data for the head row is valid here
        if (out_free) begin
          push       = 1'b1;
          push_res   = mk_result(ACT_DATA, ws_rdata, '0, '0, 1'b1);
          bcnt_next  = bcnt_inc;
          state_next = S_IDLE;
        end
      end

      S_PUSH_ONE: begin
        if (out_free) begin
          push       = 1'b1;
          push_res   = res;
          state_next = S_IDLE;
        end
      end

      S_DLV_RD: begin
        state_next = S_DLV_PUSH;
      end

      S_DLV_PUSH: begin
        if (out_free) begin
          push        = 1'b1;
          push_res    = mk_result(ACT_DELIVER, rb_rdata, POS_W'(dcount), hdr_q.rlen,
                                  dlv_last);
          dcount_next = dcount_inc;
          if (dcount_inc == hdr_q.rlen) begin
            state_next = S_POP;
          end else begin
            state_next = S_DLV_RD;
          end
        end
      end

      S_POP: begin
        head_next  = slot_sum;
        count_next = queued_count - CNT_W'(1);
        if (count_next == '0) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_START_WAIT;
        end
      end

      S_START_WAIT: begin
        // header RAM sees the current head address this cycle
        state_next = S_START;
      end

      S_START: begin
        phase_next = PH_WRITING;
        bcnt_next  = '0;
        res_next   = mk_result(ACT_ADDR, hdr_q.addr | DIR_WRITE, '0, '0, 1'b1);
        state_next = S_PUSH_ONE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_IDLE;
      head_slot    <= '0;
      queued_count <= '0;
      byte_counter <= '0;
      load_fill    <= '0;
      dcount       <= '0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      head_slot    <= head_next;
      queued_count <= count_next;
      byte_counter <= bcnt_next;
      load_fill    <= fill_next;
      dcount       <= dcount_next;
    end
  end

  // item and pending-result holding registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      itm_kind <= kind;
      itm_addr <= device_address;
      itm_wcnt <= write_count;
      itm_rcnt <= read_count;
      itm_dlv  <= wants_delivery;
      itm_data <= data_byte;
    end
    res <= res_next;
  end

  i2cq_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_res  (push_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .free      (out_free)
  );

  assign action           = out_res.action;
  assign bus_byte         = out_res.bus_byte;
  assign byte_position    = out_res.byte_position;
  assign delivered_length = out_res.delivered_length;
  assign last             = out_res.last;

  // queue occupancy stays within its ring
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    queued_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queued_count above queue depth");

  // a bus transaction is only active with a transaction in the queue
  a_phase_needs_entry: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (queued_count != '0))
    else $error("bus phase active with empty queue");

  // results are only handed over when the output register can take them
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result pushed into a full output register");

  // delivery runs only for a transaction that asked for a nonempty read
  a_dlv_hdr: assert property (@(posedge clk) disable iff (rst)
    (state == S_DLV_PUSH) |-> (hdr_q.dlv && (hdr_q.rlen != '0)))
    else $error("delivery without a delivering head transaction");

endmodule
